/* hdl/twq_pkg.sv */
`timescale 1ns / 1ps
package twq_pkg;

  // Count and register widths
  localparam int CNT_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = $clog2(CNT_W);
  localparam logic [CNT_W-1:0] HARD_STOP_RESET = 48'd10000000000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_GAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_STOP  = 3'd6;

  // Trace modes
  localparam logic [1:0] MODE_PROFILE = 2'd0;
  localparam logic [1:0] MODE_ALL     = 2'd1;
  localparam logic [1:0] MODE_UNIFORM = 2'd2;
  localparam logic [1:0] MODE_TABLE   = 2'd3;

  // Event opcodes
  localparam logic [1:0] OP_ENTER  = 2'd0;
  localparam logic [1:0] OP_INSN   = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd1;
  localparam logic [2:0] ST_STACK_FULL = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_IVAL   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHK,
    S_DIV,
    S_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic upd;
    logic div_load;
    logic div_step;
    logic fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

/* hdl/twq_ctrl.sv */
`timescale 1ns / 1ps
module twq_ctrl import twq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_UPD;
      end
      S_UPD: state_d = S_CHK;
      S_CHK: begin
        state_d = sts_i.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      S_UPD: cmd_o.upd = 1'b1;
      S_CHK: cmd_o.div_load = 1'b1;
      S_DIV: cmd_o.div_step = 1'b1;
      S_FIN: cmd_o.fin = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hdl/twq_dp.sv */
`timescale 1ns / 1ps
module twq_dp import twq_pkg::*; #(
  parameter int STACK_DEPTH    = 64,
  parameter int INTERVAL_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic [1:0]           op_i,
  input  logic                 is_traced_i,
  input  logic                 is_ret_i,
  input  logic [CNT_W-1:0]     interval_low_i,
  input  logic [CNT_W-1:0]     interval_high_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 log_now_o,
  output logic                 switch_segment_o,
  output logic                 stop_now_o,
  output logic                 in_region_o,
  output logic [2:0]           status_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
  localparam int OW = $clog2(INTERVAL_SLOTS + 1);
  localparam int TW = OW + 1;

  // Configuration
  logic [1:0]       mode_q;
  logic             roi_q;
  logic [CNT_W-1:0] wstart_q, wlen_q, wgap_q, wend_q, hstop_q;

  // Captured request
  logic [1:0]       op_q;
  logic             traced_q, ret_q;
  logic [CNT_W-1:0] lo_q, hi_q;

  // Trace state
  logic [CNT_W-1:0] total_q, region_q, lasthi_q;
  logic [DW-1:0]    depth_q, tf_q;
  logic [IW-1:0]    head_q;
  logic [OW-1:0]    occ_q;
  logic             full_q;

  // Memories
  logic             stack_mem [STACK_DEPTH];
  logic             stk_rd_q;
  logic [CNT_W-1:0] lows_mem  [INTERVAL_SLOTS];
  logic [CNT_W-1:0] highs_mem [INTERVAL_SLOTS];
  logic [CNT_W-1:0] hlo_q, hhi_q;

  // Remainder unit
  logic [CNT_W-1:0]     dvd_q;
  logic [CNT_W:0]       rem_q, rem_d;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [CNT_W+1:0]     trial;

  // Output register
  logic       ovalid_q, olog_q, osw_q, ostop_q, oreg_q;
  logic [2:0] ost_q;

  logic             region_now, mod_ok, log_v, sw_v, retire, stop_v, pop_v;
  logic             bad_v;
  logic [CNT_W-1:0] cnow;
  logic [CNT_W:0]   period;
  logic [OW-1:0]    occ_after;
  logic [TW-1:0]    tsum, tail_w, hnext_w;
  logic [2:0]       st_v;

  assign region_now = !roi_q || (tf_q != '0);
  assign cnow       = roi_q ? region_q : total_q;
  assign period     = {1'b0, wlen_q} + {1'b0, wgap_q};
  assign mod_ok     = (period != '0) && (cnow >= wstart_q);

  assign sts_o.need_div = ((op_q == OP_ENTER) || (op_q == OP_INSN)) &&
                          (mode_q == MODE_UNIFORM) && region_now && mod_ok;
  assign sts_o.div_last = (dcnt_q == DIV_CNT_W'(CNT_W - 1));
  assign sts_o.out_busy = ovalid_q;

  // One restoring step per cycle
  assign trial = {rem_q, dvd_q[CNT_W-1]};
  always_comb begin
    if (trial >= {1'b0, period}) begin
      rem_d = (CNT_W+1)'(trial - {1'b0, period});
    end else begin
      rem_d = trial[CNT_W:0];
    end
  end

  // Decision logic
  always_comb begin
    log_v = 1'b0;
    case (mode_q)
      MODE_ALL:     log_v = 1'b1;
      MODE_UNIFORM: log_v = mod_ok && (rem_q < {1'b0, wlen_q});
      MODE_TABLE:   log_v = (occ_q != '0) && (cnow >= hlo_q) && (cnow < hhi_q);
      default:      log_v = 1'b0;
    endcase
    log_v = log_v && region_now;
  end

  always_comb begin
    sw_v = 1'b0;
    if ((op_q == OP_INSN) && log_v) begin
      case (mode_q)
        MODE_UNIFORM: sw_v = (wlen_q != '0) && (rem_q == {1'b0, wlen_q - CNT_W'(1)});
        MODE_TABLE:   sw_v = (cnow == hhi_q - CNT_W'(1));
        default:      sw_v = 1'b0;
      endcase
    end
  end

  assign retire    = sw_v && (mode_q == MODE_TABLE);
  assign occ_after = occ_q - OW'(retire);
  assign pop_v     = (op_q == OP_INSN) && roi_q && ret_q;
  assign stop_v    = (total_q == hstop_q) ||
                     ((mode_q == MODE_UNIFORM) && (cnow == wend_q)) ||
                     ((mode_q == MODE_TABLE) && (occ_after == '0));
  assign bad_v     = (lo_q >= hi_q) || ((occ_q != '0) && (lo_q < lasthi_q));

  assign tsum    = TW'(head_q) + TW'(occ_q);
  assign tail_w  = (tsum >= TW'(INTERVAL_SLOTS)) ? tsum - TW'(INTERVAL_SLOTS) : tsum;
  assign hnext_w = (TW'(head_q) + TW'(1) >= TW'(INTERVAL_SLOTS)) ? '0 :
                   TW'(head_q) + TW'(1);

  always_comb begin
    st_v = ST_OK;
    case (op_q)
      OP_ENTER: if (full_q) st_v = ST_STACK_FULL;
      OP_INSN:  if (pop_v && (depth_q == '0)) st_v = ST_POP_EMPTY;
      OP_APPEND: begin
        if (bad_v) st_v = ST_BAD_IVAL;
        else if (occ_q >= OW'(INTERVAL_SLOTS)) st_v = ST_TABLE_FULL;
      end
      default: st_v = ST_OK;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PROFILE;
      roi_q    <= 1'b0;
      wstart_q <= '0;
      wlen_q   <= CNT_W'(1);
      wgap_q   <= '0;
      wend_q   <= '0;
      hstop_q  <= HARD_STOP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TRACE_MODE: mode_q   <= cfg_data_i[1:0];
        REG_ROI_MODE:   roi_q    <= cfg_data_i[0];
        REG_WIN_START:  wstart_q <= cfg_data_i;
        REG_WIN_LENGTH: wlen_q   <= cfg_data_i;
        REG_WIN_GAP:    wgap_q   <= cfg_data_i;
        REG_WIN_END:    wend_q   <= cfg_data_i;
        REG_HARD_STOP:  hstop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request capture and remainder unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= op_i;
      traced_q <= is_traced_i;
      ret_q    <= is_ret_i;
      lo_q     <= interval_low_i;
      hi_q     <= interval_high_i;
    end
    if (cmd_i.upd) begin
      full_q <= roi_q && (depth_q >= DW'(STACK_DEPTH));
    end
    if (cmd_i.div_load) begin
      dvd_q  <= cnow - wstart_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[CNT_W-2:0], 1'b0};
      rem_q  <= rem_d;
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
    end
  end

  // Frame stack memory, top entry always read
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && (op_q == OP_ENTER) && roi_q && (depth_q < DW'(STACK_DEPTH))) begin
      stack_mem[AW'(depth_q)] <= traced_q;
    end
    stk_rd_q <= stack_mem[AW'(depth_q - DW'(1))];
  end

  // Interval table memory, head entry always read
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && (op_q == OP_APPEND) && (st_v == ST_OK)) begin
      lows_mem[IW'(tail_w)]  <= lo_q;
      highs_mem[IW'(tail_w)] <= hi_q;
    end
    hlo_q <= lows_mem[head_q];
    hhi_q <= highs_mem[head_q];
  end

  // Trace state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      region_q <= '0;
      depth_q  <= '0;
      tf_q     <= '0;
      head_q   <= '0;
      occ_q    <= '0;
      lasthi_q <= '0;
    end else begin
      if (cmd_i.upd) begin
        if ((op_q == OP_ENTER) && roi_q && (depth_q < DW'(STACK_DEPTH))) begin
          depth_q <= depth_q + DW'(1);
          if (traced_q) tf_q <= tf_q + DW'(1);
        end
        if (op_q == OP_INSN) begin
          if (total_q != '1) total_q <= total_q + CNT_W'(1);
          if (roi_q && (tf_q != '0) && (region_q != '1)) region_q <= region_q + CNT_W'(1);
        end
      end
      if (cmd_i.fin) begin
        if (retire) begin
          head_q <= IW'(hnext_w);
        end
        if (op_q == OP_INSN) begin
          occ_q <= occ_after;
        end
        if (pop_v && (depth_q != '0)) begin
          depth_q <= depth_q - DW'(1);
          if (stk_rd_q && (tf_q != '0)) tf_q <= tf_q - DW'(1);
        end
        if ((op_q == OP_APPEND) && (st_v == ST_OK)) begin
          occ_q    <= occ_q + OW'(1);
          lasthi_q <= hi_q;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      olog_q  <= ((op_q == OP_ENTER) || (op_q == OP_INSN)) && log_v;
      osw_q   <= sw_v;
      ostop_q <= (op_q == OP_INSN) && stop_v;
      oreg_q  <= (op_q != OP_UNUSED) && region_now;
      ost_q   <= st_v;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign log_now_o        = olog_q;
  assign switch_segment_o = osw_q;
  assign stop_now_o       = ostop_q;
  assign in_region_o      = oreg_q;
  assign status_o         = ost_q;

endmodule

/* hdl/trace_window_qualifier.sv */
`timescale 1ns / 1ps
// Flow: an accepted request passes the update, check and finish states to
//   the result register; in uniform-window mode a function enter or
//   instruction at or past the window start also runs the bit-serial
//   remainder unit (one quotient bit per cycle). No new request is taken
//   until finish completes; finish waits while the previous result is untaken.
// Reset: asynchronous, active low; clears counts, stack depth, interval queue
//   and result valid, and loads the configuration reset values.
module trace_window_qualifier import twq_pkg::*; #(
  parameter int STACK_DEPTH    = 64,
  parameter int INTERVAL_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic                 is_traced_i,
  input  logic                 is_ret_i,
  input  logic [CNT_W-1:0]     interval_low_i,
  input  logic [CNT_W-1:0]     interval_high_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 log_now_o,
  output logic                 switch_segment_o,
  output logic                 stop_now_o,
  output logic                 in_region_o,
  output logic [2:0]           status_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  twq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twq_dp #(
    .STACK_DEPTH    (STACK_DEPTH),
    .INTERVAL_SLOTS (INTERVAL_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .is_traced_i      (is_traced_i),
    .is_ret_i         (is_ret_i),
    .interval_low_i   (interval_low_i),
    .interval_high_i  (interval_high_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .log_now_o        (log_now_o),
    .switch_segment_o (switch_segment_o),
    .stop_now_o       (stop_now_o),
    .in_region_o      (in_region_o),
    .status_o         (status_o)
  );

endmodule
